@@ rtl/cpvc_pkg.sv @@
// Shared types and codes for the convex polygon vertex checker.
package cpvc_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    typedef enum logic {
        OP_VERTEX = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_STORED      = 3'd0,
        ST_REJECTED    = 3'd1,
        ST_FULL_CLOSED = 3'd2,
        ST_IGNORED     = 3'd3,
        ST_CLEARED     = 3'd4
    } status_t;

    // x in the low half, y in the high half
    typedef struct packed {
        logic [15:0] y;
        logic [15:0] x;
    } point_t;

    typedef logic signed [16:0] coord_diff_t;
    typedef logic signed [1:0]  sign_t;

endpackage

@@ rtl/cpvc_cross_sign.sv @@
// Sign of a 2x2 cross product a*b - c*d on 17-bit signed differences.
module cpvc_cross_sign (
    input  cpvc_pkg::coord_diff_t a,
    input  cpvc_pkg::coord_diff_t b,
    input  cpvc_pkg::coord_diff_t c,
    input  cpvc_pkg::coord_diff_t d,
    output cpvc_pkg::sign_t       sign
);

    logic signed [33:0] prod_ab;
    logic signed [33:0] prod_cd;
    logic signed [34:0] cross_val;

    assign prod_ab   = a * b;
    assign prod_cd   = c * d;
    assign cross_val = $signed({prod_ab[33], prod_ab}) - $signed({prod_cd[33], prod_cd});

    always_comb begin
        if (cross_val == '0) begin
            sign = 2'sd0;
        end else if (cross_val[34]) begin
            sign = -2'sd1;
        end else begin
            sign = 2'sd1;
        end
    end

endmodule

@@ rtl/cpvc_core.sv @@
// Polygon state and the per-beat accept/reject decision.
module cpvc_core #(
    parameter int MAX_VERTICES = cpvc_pkg::MAX_VERTICES_DEF,
    parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  cpvc_pkg::opcode_t     opcode,
    input  logic [15:0]           px,
    input  logic [15:0]           py,
    output cpvc_pkg::status_t     res_status,
    output logic [CNT_W-1:0]      res_count,
    output cpvc_pkg::sign_t       res_winding
);

    cpvc_pkg::point_t first_reg, second_reg, last_reg, before_last_reg;
    cpvc_pkg::point_t first_next, second_next, last_next, before_last_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cpvc_pkg::sign_t  winding_reg, winding_next;
    logic             closed_reg, closed_next;

    cpvc_pkg::sign_t  s_start, s_prev, s_curr;
    logic             has_two, has_three, pass;

    function automatic cpvc_pkg::coord_diff_t cdiff(input logic [15:0] u, input logic [15:0] v);
        return $signed({1'b0, u}) - $signed({1'b0, v});
    endfunction

    // true when the sign opposes the known winding
    function automatic logic opposes(input cpvc_pkg::sign_t s, input cpvc_pkg::sign_t w);
        return (s != 2'sd0) && (w != 2'sd0) && (s[1] != w[1]);
    endfunction

    cpvc_cross_sign u_start (
        .a    (cdiff(first_reg.x, px)),
        .b    (cdiff(second_reg.y, first_reg.y)),
        .c    (cdiff(second_reg.x, first_reg.x)),
        .d    (cdiff(first_reg.y, py)),
        .sign (s_start)
    );

    cpvc_cross_sign u_prev (
        .a    (cdiff(last_reg.x, before_last_reg.x)),
        .b    (cdiff(py, last_reg.y)),
        .c    (cdiff(px, last_reg.x)),
        .d    (cdiff(last_reg.y, before_last_reg.y)),
        .sign (s_prev)
    );

    cpvc_cross_sign u_curr (
        .a    (cdiff(px, last_reg.x)),
        .b    (cdiff(first_reg.y, py)),
        .c    (cdiff(first_reg.x, px)),
        .d    (cdiff(py, last_reg.y)),
        .sign (s_curr)
    );

    assign has_two   = count_reg >= CNT_W'(2);
    assign has_three = count_reg >  CNT_W'(2);

    always_comb begin
        first_next       = first_reg;
        second_next      = second_reg;
        last_next        = last_reg;
        before_last_next = before_last_reg;
        count_next       = count_reg;
        winding_next     = winding_reg;
        closed_next      = closed_reg;
        res_status       = cpvc_pkg::ST_STORED;
        pass             = 1'b1;

        if (opcode == cpvc_pkg::OP_CLEAR) begin
            count_next   = '0;
            winding_next = 2'sd0;
            closed_next  = 1'b0;
            res_status   = cpvc_pkg::ST_CLEARED;
        end else if (closed_reg) begin
            res_status = cpvc_pkg::ST_IGNORED;
        end else begin
            if (has_two) begin
                if (winding_reg == 2'sd0) begin
                    // first test fixes the winding, may stay unknown
                    winding_next = s_start;
                end else begin
                    pass = !(opposes(s_start, winding_reg) ||
                             (has_three && opposes(s_prev, winding_reg)) ||
                             (has_three && opposes(s_curr, winding_reg)));
                end
            end

            if (!pass) begin
                res_status = cpvc_pkg::ST_REJECTED;
            end else if (count_reg < CNT_W'(MAX_VERTICES)) begin
                if (count_reg == CNT_W'(0)) begin
                    first_next = '{y: py, x: px};
                end else if (count_reg == CNT_W'(1)) begin
                    second_next = '{y: py, x: px};
                end
                before_last_next = last_reg;
                last_next        = '{y: py, x: px};
                count_next       = count_reg + CNT_W'(1);
                res_status       = cpvc_pkg::ST_STORED;
            end else begin
                closed_next = 1'b1;
                res_status  = cpvc_pkg::ST_FULL_CLOSED;
            end
        end
    end

    assign res_count   = count_next;
    assign res_winding = winding_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            winding_reg <= 2'sd0;
            closed_reg  <= 1'b0;
        end else if (step_en) begin
            count_reg   <= count_next;
            winding_reg <= winding_next;
            closed_reg  <= closed_next;
        end
    end

    // vertex store: no reset, read only once two vertices exist
    always_ff @(posedge aclk) begin
        if (step_en) begin
            first_reg       <= first_next;
            second_reg      <= second_next;
            last_reg        <= last_next;
            before_last_reg <= before_last_next;
        end
    end

endmodule

@@ rtl/convex_polygon_vertex_checker.sv @@
// Top level of the convex polygon vertex checker: input register, core, result register.
//
// Each input beat either clears the polygon or offers a vertex; every beat yields exactly
// one result beat carrying a status, the vertex count after the step and the winding
// sign (-1, +1, or 0 while unknown). A beat is taken into an input register, evaluated
// combinationally by the core (three cross-product signs, six 17x17 multiplies in parallel,
// and the state update), and the result lands in an output register. Throughput is one
// beat per cycle while m_ready does not hold the output register; the result is written
// into the output register when its beat leaves the input register. The state
// write in the core sets the rate: each beat needs the state left by the one before it,
// and that update completes in the same cycle the beat leaves the input register.
// The output register lets a new beat enter while a result waits for m_ready. Only the
// first, second, last and second-to-last vertices are kept, so MAX_VERTICES sets only
// the counter and the m_vertex_count width ($clog2(MAX_VERTICES+1) bits).
module convex_polygon_vertex_checker #(
    parameter int MAX_VERTICES = cpvc_pkg::MAX_VERTICES_DEF,
    parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    input  logic [15:0]       s_px,
    input  logic [15:0]       s_py,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [CNT_W-1:0]  m_vertex_count,
    output logic signed [1:0] m_winding
);

    // input stage
    logic              in_valid_reg;
    cpvc_pkg::opcode_t in_opcode_reg;
    logic [15:0]       in_px_reg;
    logic [15:0]       in_py_reg;

    // result stage
    logic              out_valid_reg;
    cpvc_pkg::status_t out_status_reg;
    logic [CNT_W-1:0]  out_count_reg;
    cpvc_pkg::sign_t   out_winding_reg;

    // core results for the beat in the input stage
    cpvc_pkg::status_t core_status;
    logic [CNT_W-1:0]  core_count;
    cpvc_pkg::sign_t   core_winding;

    logic out_free;
    logic advance;

    // result register can take a new beat when empty or being drained
    assign out_free = !out_valid_reg || m_ready;
    // the beat in the input stage moves on and commits its state update
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    cpvc_core #(
        .MAX_VERTICES (MAX_VERTICES),
        .CNT_W        (CNT_W)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .opcode      (in_opcode_reg),
        .px          (in_px_reg),
        .py          (in_py_reg),
        .res_status  (core_status),
        .res_count   (core_count),
        .res_winding (core_winding)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg <= cpvc_pkg::opcode_t'(s_opcode);
            in_px_reg     <= s_px;
            in_py_reg     <= s_py;
        end
        if (advance) begin
            out_status_reg  <= core_status;
            out_count_reg   <= core_count;
            out_winding_reg <= core_winding;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_vertex_count = out_count_reg;
    assign m_winding      = out_winding_reg;

endmodule

@@ rtl/cpvc_checker.sv @@
// Port-level assertions for the convex polygon vertex checker, bound to the top level.
module cpvc_checker #(
    parameter int MAX_VERTICES = cpvc_pkg::MAX_VERTICES_DEF,
    parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [2:0]        m_status,
    input logic [CNT_W-1:0]  m_vertex_count,
    input logic signed [1:0] m_winding
);

    // no result beat straight out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
            $stable(m_vertex_count) && $stable(m_winding))
        else $error("stalled result beat changed");

    // a clear empties the polygon and forgets the winding
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == cpvc_pkg::ST_CLEARED |->
            m_vertex_count == '0 && m_winding == 2'sd0)
        else $error("clear left state behind");

    // closing only happens with a full store
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == cpvc_pkg::ST_FULL_CLOSED |->
            m_vertex_count == CNT_W'(MAX_VERTICES))
        else $error("polygon closed before store full");

    // winding is known once a vertex has been rejected, and never -2
    a_winding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == cpvc_pkg::ST_REJECTED |->
            (m_winding == 2'sd1 || m_winding == -2'sd1) && m_vertex_count >= CNT_W'(2))
        else $error("rejection without a known winding");

endmodule

bind convex_polygon_vertex_checker cpvc_checker #(
    .MAX_VERTICES (MAX_VERTICES),
    .CNT_W        (CNT_W)
) u_cpvc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_vertex_count (m_vertex_count),
    .m_winding      (m_winding)
);

@@ test/tb_top.sv @@
// Self-checking testbench for the convex polygon vertex checker.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_VERTS = cpvc_pkg::MAX_VERTICES_DEF;
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);
    localparam int NUM_DIRECTED = 16;
    localparam int RANDOM_BEATS = 1000;
    localparam int HOLD_CYCLES  = 64;

    // One result beat as the block should produce it.
    typedef struct packed {
        cpvc_pkg::status_t  status;
        logic [CNT_W-1:0]   count;
        logic signed [1:0]  winding;
    } poly_result_t;

    // Directed stimulus; typed expectations are used only where typed is set.
    typedef struct {
        cpvc_pkg::opcode_t op;
        logic [15:0]       x;
        logic [15:0]       y;
        bit                typed;
        cpvc_pkg::status_t exp_status;
        int                exp_count;
        int                exp_winding;
    } dir_row_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_opcode = 1'b0;
    logic [15:0]       s_px = '0;
    logic [15:0]       s_py = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [2:0]        m_status;
    logic [CNT_W-1:0]  m_vertex_count;
    logic signed [1:0] m_winding;

    // Predictor state: the four kept vertices, count, winding and closed flag.
    cpvc_pkg::point_t poly_first, poly_second, poly_last, poly_before_last;
    int     poly_count   = 0;
    int     poly_winding = 0;
    bit     poly_closed  = 1'b0;

    poly_result_t pending_results[$];
    int mismatches    = 0;
    int beats_counted = 0;   // accepted beats the block did not merely ignore

    // Idling knobs, in percent of cycles, and the long receiver hold-off request.
    int send_gap_pct = 26;
    int recv_gap_pct = 53;
    int hold_serial  = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    dir_row_t directed_rows [NUM_DIRECTED];

    convex_polygon_vertex_checker dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_px           (s_px),
        .s_py           (s_py),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_vertex_count (m_vertex_count),
        .m_winding      (m_winding)
    );

    always #10 aclk = ~aclk;

    // Sign of a*d - b*c, exact in 64 bits.
    function automatic int turn_sign(longint a, longint d, longint b, longint c);
        longint v;
        v = a * d - b * c;
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Applies one beat to the predictor state and returns the result it should give.
    function automatic poly_result_t next_polygon_result(cpvc_pkg::opcode_t op,
                                                         logic [15:0] x, logic [15:0] y);
        poly_result_t     res;
        cpvc_pkg::point_t p;
        bit               convex;
        int               s_start, s_prev, s_curr;
        longint           px, py, fx, fy, sx, sy, lx, ly, bx, by;
        p       = '{y: y, x: x};
        convex  = 1'b1;
        s_prev  = 0;
        s_curr  = 0;
        px = longint'(x);                 py = longint'(y);
        fx = longint'(poly_first.x);      fy = longint'(poly_first.y);
        sx = longint'(poly_second.x);     sy = longint'(poly_second.y);
        lx = longint'(poly_last.x);       ly = longint'(poly_last.y);
        bx = longint'(poly_before_last.x); by = longint'(poly_before_last.y);
        if (op == cpvc_pkg::OP_CLEAR) begin
            poly_count   = 0;
            poly_winding = 0;
            poly_closed  = 1'b0;
            res.status   = cpvc_pkg::ST_CLEARED;
        end else if (poly_closed) begin
            res.status = cpvc_pkg::ST_IGNORED;
        end else begin
            // below two vertices anything goes; the kept vertices are only read from two on
            if (poly_count >= 2) begin
                s_start = turn_sign(fx - px, sy - fy, sx - fx, fy - py);
                if (poly_count > 2) begin
                    s_prev = turn_sign(lx - bx, py - ly, px - lx, ly - by);
                    s_curr = turn_sign(px - lx, fy - py, fx - px, py - ly);
                end
                if (poly_winding == 0)
                    poly_winding = s_start;     // may stay unknown on collinear points
                else
                    convex = !(s_start * poly_winding < 0 || s_prev * poly_winding < 0 ||
                               s_curr * poly_winding < 0);
            end
            if (!convex) begin
                res.status = cpvc_pkg::ST_REJECTED;
            end else if (poly_count < MAX_VERTS) begin
                if (poly_count == 0)
                    poly_first = p;
                else if (poly_count == 1)
                    poly_second = p;
                poly_before_last = poly_last;
                poly_last        = p;
                poly_count++;
                res.status = cpvc_pkg::ST_STORED;
            end else begin
                poly_closed = 1'b1;
                res.status  = cpvc_pkg::ST_FULL_CLOSED;
            end
        end
        res.count   = CNT_W'(poly_count);
        res.winding = 2'(poly_winding);
        return res;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < 100)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Offers one beat and holds it until taken; the expectation is queued on acceptance.
    task automatic offer_beat(cpvc_pkg::opcode_t op, logic [15:0] x, logic [15:0] y,
                              bit typed, poly_result_t typed_res);
        poly_result_t res;
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_opcode = op;
        s_px     = x;
        s_py     = y;
        do @(posedge aclk); while (!s_ready);
        res = next_polygon_result(op, x, y);
        if (res.status != cpvc_pkg::ST_IGNORED)
            beats_counted++;
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Sender pause: valid drops and nothing is offered until every result is back.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
    always @(negedge aclk) begin
        if (hold_serial != hold_seen) begin
            hold_seen = hold_serial;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Result checker: every accepted result beat against the oldest expectation.
    always @(posedge aclk) begin : result_monitor
        poly_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected (status %0d)",
                                          m_status));
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_status, want.status));
                if (m_vertex_count !== want.count)
                    report_mismatch($sformatf("vertex count %0d, expected %0d",
                                              m_vertex_count, want.count));
                if (m_winding !== want.winding)
                    report_mismatch($sformatf("winding %0d, expected %0d",
                                              m_winding, want.winding));
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        poly_result_t      typed_res, no_typed;
        cpvc_pkg::opcode_t op;
        logic [15:0]       px, py;
        int                i, k, n, kind, rad, cx, cy, xi, yi, dx, dy, x0, y0;
        int                rand_base, done, phase, holds;
        real               a0, turn, ang;
        bit                flip;

        no_typed = '0;

        // Directed part. Square corners at the coordinate extremes set a positive
        // winding; a point on the closing edge is collinear and passes, an interior
        // point fails. Then a collinear run keeps the winding unknown until a
        // point off the line sets it negative.
        directed_rows = '{
            '{cpvc_pkg::OP_CLEAR,  16'd0,     16'd0,     1'b1, cpvc_pkg::ST_CLEARED, 0, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd0,     16'd0,     1'b1, cpvc_pkg::ST_STORED,  1, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd65535, 16'd0,     1'b1, cpvc_pkg::ST_STORED,  2, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd65535, 16'd65535, 1'b0, cpvc_pkg::ST_STORED,  0, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd0,     16'd65535, 1'b0, cpvc_pkg::ST_STORED,  0, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd0,     16'd32768, 1'b0, cpvc_pkg::ST_STORED,  0, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd32768, 16'd32768, 1'b0, cpvc_pkg::ST_STORED,  0, 0},
            '{cpvc_pkg::OP_CLEAR,  16'd65535, 16'd65535, 1'b1, cpvc_pkg::ST_CLEARED, 0, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd10,    16'd10,    1'b1, cpvc_pkg::ST_STORED,  1, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd20,    16'd20,    1'b1, cpvc_pkg::ST_STORED,  2, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd30,    16'd30,    1'b0, cpvc_pkg::ST_STORED,  0, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd40,    16'd40,    1'b0, cpvc_pkg::ST_STORED,  0, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd40,    16'd0,     1'b0, cpvc_pkg::ST_STORED,  0, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd65535, 16'd65535, 1'b0, cpvc_pkg::ST_STORED,  0, 0},
            '{cpvc_pkg::OP_VERTEX, 16'd0,     16'd65535, 1'b0, cpvc_pkg::ST_STORED,  0, 0},
            '{cpvc_pkg::OP_CLEAR,  16'd12345, 16'd54321, 1'b1, cpvc_pkg::ST_CLEARED, 0, 0}
        };

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++) begin
            typed_res.status  = directed_rows[i].exp_status;
            typed_res.count   = CNT_W'(directed_rows[i].exp_count);
            typed_res.winding = 2'(directed_rows[i].exp_winding);
            offer_beat(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                       directed_rows[i].typed, typed_res);
        end
        wait_for_drain();

        // Random part: mostly well-formed convex outlines and collinear runs that fill
        // the store, with noise and broken outlines mixed in.
        rand_base = beats_counted;
        phase     = 0;
        holds     = 0;
        done      = 0;
        while (done < RANDOM_BEATS) begin
            // swap idling sides after a third, stop idling after two thirds
            if (phase == 0 && done >= RANDOM_BEATS / 3) begin
                wait_for_drain();
                phase        = 1;
                send_gap_pct = 53;
                recv_gap_pct = 26;
            end else if (phase == 1 && done >= 2 * RANDOM_BEATS / 3) begin
                wait_for_drain();
                phase        = 2;
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            // long receiver hold-offs while the sender keeps pushing
            if ((holds == 0 && done >= 150) || (holds == 1 && done >= 800)) begin
                hold_serial++;
                holds++;
            end

            kind = $urandom_range(99);
            if (kind < 50) begin
                // vertices round a circle in angular order, either direction
                n = ($urandom_range(7) == 0) ? $urandom_range(66, 72) : $urandom_range(3, 20);
                rad  = (n > 20) ? $urandom_range(2000, 32000) : $urandom_range(4, 32000);
                cx   = $urandom_range(rad, 65535 - rad);
                cy   = $urandom_range(rad, 65535 - rad);
                a0   = real'($urandom_range(6283)) / 1000.0;
                turn = $urandom_range(1) ? 6.283185307 : -6.283185307;
                if ($urandom_range(3) != 0)
                    offer_beat(cpvc_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 1'b0,
                               no_typed);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(9) == 0) begin
                        px = 16'($urandom);
                        py = 16'($urandom);
                    end else begin
                        ang = a0 + turn * real'(k) / real'(n);
                        xi  = int'(real'(cx) + real'(rad) * $cos(ang));
                        yi  = int'(real'(cy) + real'(rad) * $sin(ang));
                        xi  = (xi < 0) ? 0 : ((xi > 65535) ? 65535 : xi);
                        yi  = (yi < 0) ? 0 : ((yi > 65535) ? 65535 : yi);
                        px  = 16'(xi);
                        py  = 16'(yi);
                    end
                    offer_beat(cpvc_pkg::OP_VERTEX, px, py, 1'b0, no_typed);
                end
            end else if (kind < 62) begin
                // collinear run: winding stays unknown; runs longer than the store fill it and close it
                dx   = $urandom_range(0, 300);
                dy   = $urandom_range(0, 300);
                x0   = $urandom_range(0, 65535 - 75 * dx);
                y0   = $urandom_range(0, 65535 - 75 * dy);
                flip = 1'($urandom_range(1));
                n    = $urandom_range(62, 70);
                offer_beat(cpvc_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 1'b0, no_typed);
                for (k = 0; k < n; k++) begin
                    xi = x0 + k * dx;
                    yi = y0 + k * dy;
                    px = flip ? 16'(65535 - xi) : 16'(xi);
                    py = 16'(yi);
                    offer_beat(cpvc_pkg::OP_VERTEX, px, py, 1'b0, no_typed);
                end
            end else begin
                // noise, weighted towards the coordinate extremes
                n = $urandom_range(4, 16);
                for (k = 0; k < n; k++) begin
                    op = ($urandom_range(9) == 0) ? cpvc_pkg::OP_CLEAR : cpvc_pkg::OP_VERTEX;
                    px = ($urandom_range(3) == 0) ? {16{1'($urandom)}} : 16'($urandom);
                    py = ($urandom_range(3) == 0) ? {16{1'($urandom)}} : 16'($urandom);
                    offer_beat(op, px, py, 1'b0, no_typed);
                end
            end
            done = beats_counted - rand_base;
        end

        wait_for_drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
